// ----- rtl/actr_pkg.sv -----
// shared constants for the associative tag table with replacement
`default_nettype none
package actr_pkg;

    // default number of table slots
    localparam int ENTRIES_DEF = 8;

    // age floor follows a five bit signed order
    localparam int AGE_FLOOR_BITS = 5;
    localparam int AGE_FLOOR      = -(1 << (AGE_FLOOR_BITS - 1));

    // width of the slot field in a result beat
    localparam int SLOT_OUT_W = 3;

    // key width as hashed upstream
    localparam int KEY_W = 64;

    // result beat width, padded to whole bytes
    localparam int OUT_DATA_W = 8;

    // request kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/actr_slot_ram.sv -----
// key and age storage for the tag table, one write port and one registered read port
`default_nettype none
module actr_slot_ram
    import actr_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = 3,
    parameter int AGE_W   = 5
)
(
    input  wire logic                    clk,
    input  wire logic [IDX_W-1:0]        rd_addr,
    output logic      [KEY_W-1:0]        rd_key,
    output logic signed [AGE_W-1:0]      rd_age,
    input  wire logic                    wr_en,
    input  wire logic                    wr_key_en,
    input  wire logic [IDX_W-1:0]        wr_addr,
    input  wire logic [KEY_W-1:0]        wr_key,
    input  wire logic signed [AGE_W-1:0] wr_age
);

    logic        [KEY_W-1:0] key_mem [ENTRIES];
    logic signed [AGE_W-1:0] age_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_key_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_en)
        begin
            age_mem[wr_addr] <= wr_age;
        end
    end

    // read data registered, no reset
    always_ff @(posedge clk)
    begin
        rd_key <= key_mem[rd_addr];
        rd_age <= age_mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- rtl/assoc_cache_tag_replace_unit.sv -----
// top level of the fully associative tag table with oldest-insert replacement
// lookup: a scan from the accepted beat to the result, with an early exit on a hit
// insert: a victim scan that stops at a free slot, then an age pass
// both passes run one slot a cycle through the single read port of the slot ram
// only one request in flight; the next beat is accepted once the result has been registered
// reset clears all valid bits and the sequencer at once; keys and ages need no clearing pass
`default_nettype none
module assoc_cache_tag_replace_unit
    import actr_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [KEY_W-1:0]      s_axis_tdata,   // [63:0] key
    input  wire logic [0:0]            s_axis_tuser,   // [0] kind
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [OUT_DATA_W-1:0] m_axis_tdata    // [0] hit, [3:1] slot, [4] evicted_valid
);

    // index and age widths follow the table size
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int AGE_REQ = $clog2(ENTRIES + 2) + 1;
    localparam int AGE_W   = (AGE_REQ > AGE_FLOOR_BITS) ? AGE_REQ : AGE_FLOOR_BITS;

    localparam logic signed [AGE_W-1:0] AGE_LO  = AGE_W'(AGE_FLOOR);
    localparam logic signed [AGE_W-1:0] AGE_TOP = AGE_W'(ENTRIES + 1);
    localparam logic signed [AGE_W-1:0] AGE_ONE = AGE_W'(1);
    localparam logic [IDX_W-1:0]        LAST    = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W:0]          ADDR_END = (IDX_W + 1)'(ENTRIES);
    localparam logic [IDX_W:0]          ADDR_ONE = (IDX_W + 1)'(1);

    // sequencer states, one-hot
    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_AGE  = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t                  state_reg,      state_next;
    logic                    kind_reg,       kind_next;
    logic [KEY_W-1:0]        key_reg,        key_next;
    logic [IDX_W:0]          addr_reg,       addr_next;     // next slot to read
    logic                    pend_reg,       pend_next;     // ram output holds a slot
    logic [IDX_W-1:0]        pend_idx_reg,   pend_idx_next; // slot on the ram output
    logic                    have_reg,       have_next;
    logic [IDX_W-1:0]        best_idx_reg,   best_idx_next;
    logic signed [AGE_W-1:0] best_age_reg,   best_age_next;
    logic [IDX_W-1:0]        res_idx_reg,    res_idx_next;  // victim on insert, match on hit
    logic                    res_hit_reg,    res_hit_next;
    logic                    res_evict_reg,  res_evict_next;
    logic [ENTRIES-1:0]      valid_reg,      valid_next;
    logic                    out_valid_reg,  out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg,   out_data_next;

    // slot ram ports
    logic        [KEY_W-1:0] rd_key;
    logic signed [AGE_W-1:0] rd_age;
    logic                    wr_en;
    logic                    wr_key_en;
    logic signed [AGE_W-1:0] wr_age;

    // scan helpers
    logic                    issue;
    logic                    ent_valid;
    logic                    better;
    logic [IDX_W-1:0]        cand_idx;
    logic [IDX_W+2:0]        slot_ext;

    actr_slot_ram #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .AGE_W   (AGE_W)
    ) u_slot_ram (
        .clk       (clk),
        .rd_addr   (addr_reg[IDX_W-1:0]),
        .rd_key    (rd_key),
        .rd_age    (rd_age),
        .wr_en     (wr_en),
        .wr_key_en (wr_key_en),
        .wr_addr   (pend_idx_reg),
        .wr_key    (key_reg),
        .wr_age    (wr_age)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // the shared compare unit sees one slot a cycle from the ram output
    assign issue     = (addr_reg < ADDR_END);
    assign ent_valid = valid_reg[pend_idx_reg];
    assign better    = !have_reg || (rd_age < best_age_reg);
    assign cand_idx  = better ? pend_idx_reg : best_idx_reg;

    // slot index zero-extended; the result field takes its low SLOT_OUT_W bits
    assign slot_ext  = {3'b000, res_idx_reg};

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        have_next      = have_reg;
        best_idx_next  = best_idx_reg;
        best_age_next  = best_age_reg;
        res_idx_next   = res_idx_reg;
        res_hit_next   = res_hit_reg;
        res_evict_next = res_evict_reg;
        valid_next     = valid_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        wr_en          = 1'b0;
        wr_key_en      = 1'b0;
        wr_age         = AGE_TOP;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_next  = s_axis_tuser[0];
                    key_next   = s_axis_tdata;
                    addr_next  = '0;
                    pend_next  = 1'b0;
                    have_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // keep the read pipe running
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg[IDX_W-1:0];
                    addr_next     = addr_reg + ADDR_ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (kind_reg == KIND_LOOKUP)
                    begin
                        if (ent_valid && (rd_key == key_reg))
                        begin
                            res_hit_next   = 1'b1;
                            res_idx_next   = pend_idx_reg;
                            res_evict_next = 1'b0;
                            state_next     = ST_RESP;
                        end
                        else if (pend_idx_reg == LAST)
                        begin
                            // miss reports slot zero
                            res_hit_next   = 1'b0;
                            res_idx_next   = '0;
                            res_evict_next = 1'b0;
                            state_next     = ST_RESP;
                        end
                    end
                    else
                    begin
                        if (!ent_valid)
                        begin
                            // first free slot wins
                            res_hit_next   = 1'b0;
                            res_idx_next   = pend_idx_reg;
                            res_evict_next = 1'b0;
                            addr_next      = '0;
                            pend_next      = 1'b0;
                            state_next     = ST_AGE;
                        end
                        else
                        begin
                            if (better)
                            begin
                                have_next     = 1'b1;
                                best_idx_next = pend_idx_reg;
                                best_age_next = rd_age;
                            end
                            if (pend_idx_reg == LAST)
                            begin
                                // table full, evict the oldest
                                res_hit_next   = 1'b0;
                                res_idx_next   = cand_idx;
                                res_evict_next = 1'b1;
                                addr_next      = '0;
                                pend_next      = 1'b0;
                                state_next     = ST_AGE;
                            end
                        end
                    end
                end
            end

            ST_AGE:
            begin
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg[IDX_W-1:0];
                    addr_next     = addr_reg + ADDR_ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    // read-modify-write of one age a cycle
                    wr_en = 1'b1;
                    if (pend_idx_reg == res_idx_reg)
                    begin
                        wr_key_en               = 1'b1;
                        wr_age                  = AGE_TOP;
                        valid_next[res_idx_reg] = 1'b1;
                    end
                    else if (rd_age > AGE_LO)
                    begin
                        wr_age = rd_age - AGE_ONE;
                    end
                    else
                    begin
                        wr_age = rd_age;
                    end

                    if (pend_idx_reg == LAST)
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_RESP:
            begin
                // load the output register once it is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, res_evict_reg, slot_ext[SLOT_OUT_W-1:0],
                                      res_hit_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and scan working registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        addr_reg      <= addr_next;
        pend_idx_reg  <= pend_idx_next;
        have_reg      <= have_next;
        best_idx_reg  <= best_idx_next;
        best_age_reg  <= best_age_next;
        res_idx_reg   <= res_idx_next;
        res_hit_reg   <= res_hit_next;
        res_evict_reg <= res_evict_next;
        out_data_reg  <= out_data_next;
    end

endmodule
`default_nettype wire

// ----- dv/assoc_cache_tag_replace_unit_checker.sv -----
// beat monitor, tag table predictor and result scoreboard for the tag replace unit
module assoc_cache_tag_replace_unit_checker
    import actr_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [KEY_W-1:0]      s_axis_tdata,   // [63:0] key
    input  wire logic [0:0]            s_axis_tuser,   // [0] kind
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] hit, [3:1] slot, [4] evicted_valid
    output int                         fault_count,
    output int                         pending_count
);

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted;
    } tag_result_t;

    logic             tbl_valid [ENTRIES];
    logic [KEY_W-1:0] tbl_key   [ENTRIES];
    int               tbl_age   [ENTRIES];

    tag_result_t      tag_results_q [$];

    initial fault_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d want %0d", $realtime, what, got, want);
        fault_count++;
    endtask

    // lookup leaves the table alone, insert replaces a slot and ages the rest
    function automatic tag_result_t resolve_request(input logic kind, input logic [KEY_W-1:0] key);
        tag_result_t res;
        int          victim;
        bool_found:
        begin
        end
        res    = '0;
        victim = -1;
        if (kind == KIND_LOOKUP)
        begin
            for (int i = ENTRIES - 1; i >= 0; i--)
            begin
                if (tbl_valid[i] && tbl_key[i] == key)
                begin
                    res.hit  = 1'b1;
                    res.slot = SLOT_OUT_W'(i);
                end
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES && victim < 0; i++)
            begin
                if (!tbl_valid[i])
                    victim = i;
            end
            if (victim < 0)
            begin
                victim = 0;
                for (int i = 1; i < ENTRIES; i++)
                begin
                    if (tbl_age[i] < tbl_age[victim])
                        victim = i;
                end
            end
            res.evicted       = tbl_valid[victim];
            res.slot          = SLOT_OUT_W'(victim);
            tbl_key[victim]   = key;
            tbl_valid[victim] = 1'b1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (i == victim)
                    tbl_age[i] = ENTRIES + 1;
                else if (tbl_age[i] > AGE_FLOOR)
                    tbl_age[i] = tbl_age[i] - 1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tag_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tbl_valid[i] = 1'b0;
                tbl_key[i]   = '0;
                tbl_age[i]   = 0;
            end
            tag_results_q.delete();
            pending_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (tag_results_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing outstanding", $realtime);
                    fault_count++;
                end
                else
                begin
                    want = tag_results_q.pop_front();
                    if (m_axis_tdata[0] !== want.hit)
                        report_mismatch("hit", int'(m_axis_tdata[0]), int'(want.hit));
                    if (m_axis_tdata[3:1] !== want.slot)
                        report_mismatch("slot", int'(m_axis_tdata[3:1]), int'(want.slot));
                    if (m_axis_tdata[4] !== want.evicted)
                        report_mismatch("evicted_valid", int'(m_axis_tdata[4]),
                                        int'(want.evicted));
                    if (m_axis_tdata[OUT_DATA_W-1:5] !== '0)
                        report_mismatch("pad", int'(m_axis_tdata[OUT_DATA_W-1:5]), 0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                tag_results_q.push_back(resolve_request(s_axis_tuser[0], s_axis_tdata));
            pending_count = tag_results_q.size();
        end
    end

endmodule

// ----- dv/assoc_cache_tag_replace_unit_test.sv -----
// stimulus and verdict for the tag replace unit, with the checker beside the block
module assoc_cache_tag_replace_unit_test;
    import actr_pkg::*;

    localparam int NUM_SLOTS    = ENTRIES_DEF;
    // worst request is an insert: victim scan plus age pass
    localparam int TAIL_CYCLES  = 2 * NUM_SLOTS + 3 + 8;
    localparam int RANDOM_BEATS = 1630;
    localparam int QUIET_TAIL   = 150;
    localparam int POOL_SIZE    = 16;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [KEY_W-1:0]      s_axis_tdata;   // [63:0] key
    logic [0:0]            s_axis_tuser;   // [0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] hit, [3:1] slot, [4] evicted_valid

    int                    fault_count;
    int                    pending_count;

    // random idling on both sides while this is set
    logic                  bursts_on;
    int                    stall_left;

    logic [KEY_W-1:0]      key_pool [POOL_SIZE];

    assoc_cache_tag_replace_unit #(
        .ENTRIES(NUM_SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    assoc_cache_tag_replace_unit_checker #(
        .ENTRIES(NUM_SLOTS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .fault_count  (fault_count),
        .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: ready with random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 4);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // one request beat; an optional idle gap first, then hold until accepted
    task automatic send_request(input logic kind, input logic [KEY_W-1:0] key);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= key;
        s_axis_tuser[0] <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // timeout guard, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("assoc_cache_tag_replace_unit_test: errors");
        $finish;
    end

    initial
    begin
        logic             kind;
        logic [KEY_W-1:0] key;
        int               pick;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        bursts_on     <= 1'b1;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = random_key();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: misses on an empty table at both key extremes
        send_request(KIND_LOOKUP, '0);
        send_request(KIND_LOOKUP, '1);
        // fill from slot 0 upward, including a duplicate key
        send_request(KIND_INSERT, '0);
        send_request(KIND_INSERT, '1);
        send_request(KIND_LOOKUP, '0);
        send_request(KIND_LOOKUP, '1);
        send_request(KIND_INSERT, '0);
        send_request(KIND_LOOKUP, '0);
        send_request(KIND_INSERT, {32{2'b01}});
        send_request(KIND_INSERT, {32{2'b10}});
        send_request(KIND_INSERT, key_pool[0]);
        send_request(KIND_INSERT, key_pool[1]);
        send_request(KIND_INSERT, key_pool[2]);
        // table full: inserts now evict the oldest slot
        send_request(KIND_INSERT, key_pool[3]);
        send_request(KIND_LOOKUP, '0);
        send_request(KIND_INSERT, key_pool[4]);
        send_request(KIND_LOOKUP, '1);
        send_request(KIND_LOOKUP, key_pool[3]);
        send_request(KIND_LOOKUP, key_pool[3] ^ 64'h1);
        send_request(KIND_INSERT, key_pool[3]);
        send_request(KIND_LOOKUP, key_pool[3]);

        // random: mostly keys from a small pool so lookups hit and duplicates build up,
        // some near misses one bit away, some fully random keys
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n >= RANDOM_BEATS - QUIET_TAIL)
                bursts_on <= 1'b0;
            else
                bursts_on <= ((n % 300) < 230);
            kind = ($urandom_range(0, 9) < 4) ? KIND_INSERT : KIND_LOOKUP;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 8)
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)]
                      ^ (64'h1 << $urandom_range(0, KEY_W - 1));
            else
                key = random_key();
            // refresh part of the pool now and then so old keys age out
            if ($urandom_range(0, 99) == 0)
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
            send_request(kind, key);
        end
        s_axis_tvalid <= 1'b0;

        // drain: every request gives exactly one result beat
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("assoc_cache_tag_replace_unit_test: clean");
        else
            $display("assoc_cache_tag_replace_unit_test: errors");
        $finish;
    end

endmodule
